### rtl/bstme_pkg.sv
// Shared constants, operation codes and controller/datapath interface types
// for the budget-limited spanning tree block. No dependencies.
package bstme_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int MAX_EDGES = 496;
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int EADDR_W = $clog2(MAX_EDGES);
	localparam int CNT_W = $clog2(MAX_EDGES + 1);
	localparam int VTX_W = 6;
	localparam int WT_W = 32;
	localparam int SUM_W = 48;
	localparam int ANS_W = 30;
	localparam int EDGE_W = 2 * VTX_W + WT_W;
	localparam logic [ANS_W-1:0] ANSWER_CAP = ANS_W'(1000000000);

	localparam logic CFG_VERTEX_COUNT = 1'b0;
	localparam logic CFG_BUDGET = 1'b1;

	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 5'd1;
	localparam logic [OP_W-1:0] OP_RD_I = 5'd2;
	localparam logic [OP_W-1:0] OP_HOLD = 5'd3;
	localparam logic [OP_W-1:0] OP_RD_JM1 = 5'd4;
	localparam logic [OP_W-1:0] OP_WR_HOLD = 5'd5;
	localparam logic [OP_W-1:0] OP_WR_SHIFT = 5'd6;
	localparam logic [OP_W-1:0] OP_SRCH_INIT = 5'd7;
	localparam logic [OP_W-1:0] OP_PROBE = 5'd8;
	localparam logic [OP_W-1:0] OP_K_INIT = 5'd9;
	localparam logic [OP_W-1:0] OP_K_RD = 5'd10;
	localparam logic [OP_W-1:0] OP_K_LD = 5'd11;
	localparam logic [OP_W-1:0] OP_FA = 5'd12;
	localparam logic [OP_W-1:0] OP_FB = 5'd13;
	localparam logic [OP_W-1:0] OP_K_END = 5'd14;
	localparam logic [OP_W-1:0] OP_EMIT = 5'd15;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic i_lt_cnt;
		logic j_zero;
		logic cmp_gt;
		logic v_last;
		logic pos_lt_cnt;
		logic range_ok;
		logic is_root;
		logic final_run;
		logic out_busy;
	} status_t;

endpackage

### rtl/bstme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bstme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/bstme_ctrl.sv
// Sequencer for load, insertion sort, binary search and union-find passes.
// Depends on bstme_pkg.
module bstme_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_edge,
	output logic               in_stall,
	input  bstme_pkg::status_t sts,
	output bstme_pkg::cmd_t    cmd
);

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_SCHK = 4'd1;
	localparam logic [3:0] ST_SRDI = 4'd2;
	localparam logic [3:0] ST_SCRD = 4'd3;
	localparam logic [3:0] ST_SCMP = 4'd4;
	localparam logic [3:0] ST_SRCH = 4'd5;
	localparam logic [3:0] ST_KINIT = 4'd6;
	localparam logic [3:0] ST_KEDGE = 4'd7;
	localparam logic [3:0] ST_KLD = 4'd8;
	localparam logic [3:0] ST_FA = 4'd9;
	localparam logic [3:0] ST_FB = 4'd10;
	localparam logic [3:0] ST_OUT = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != ST_LOAD);

	always_comb begin
		state_d = state_q;
		cmd.op = bstme_pkg::OP_NONE;
		case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.op = bstme_pkg::OP_LOAD;
					if (last_edge) state_d = ST_SCHK;
				end
			end
			ST_SCHK: begin
				if (sts.i_lt_cnt) begin
					cmd.op = bstme_pkg::OP_RD_I;
					state_d = ST_SRDI;
				end else begin
					cmd.op = bstme_pkg::OP_SRCH_INIT;
					state_d = ST_SRCH;
				end
			end
			ST_SRDI: begin
				cmd.op = bstme_pkg::OP_HOLD;
				state_d = ST_SCRD;
			end
			ST_SCRD: begin
				if (sts.j_zero) begin
					cmd.op = bstme_pkg::OP_WR_HOLD;
					state_d = ST_SCHK;
				end else begin
					cmd.op = bstme_pkg::OP_RD_JM1;
					state_d = ST_SCMP;
				end
			end
			ST_SCMP: begin
				if (sts.cmp_gt) begin
					cmd.op = bstme_pkg::OP_WR_SHIFT;
					state_d = ST_SCRD;
				end else begin
					cmd.op = bstme_pkg::OP_WR_HOLD;
					state_d = ST_SCHK;
				end
			end
			ST_SRCH: begin
				cmd.op = bstme_pkg::OP_PROBE;
				state_d = ST_KINIT;
			end
			ST_KINIT: begin
				cmd.op = bstme_pkg::OP_K_INIT;
				if (sts.v_last) state_d = ST_KEDGE;
			end
			ST_KEDGE: begin
				if (sts.pos_lt_cnt) begin
					cmd.op = bstme_pkg::OP_K_RD;
					state_d = ST_KLD;
				end else begin
					cmd.op = bstme_pkg::OP_K_END;
					state_d = sts.final_run ? ST_OUT : ST_SRCH;
				end
			end
			ST_KLD: begin
				cmd.op = bstme_pkg::OP_K_LD;
				state_d = sts.range_ok ? ST_FA : ST_KEDGE;
			end
			ST_FA: begin
				cmd.op = bstme_pkg::OP_FA;
				if (sts.is_root) state_d = ST_FB;
			end
			ST_FB: begin
				cmd.op = bstme_pkg::OP_FB;
				if (sts.is_root) state_d = ST_KEDGE;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.op = bstme_pkg::OP_EMIT;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_only_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bstme_pkg::OP_LOAD) |-> (!in_stall && in_valid))
		else $error("load issued while input closed");
	a_emit_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bstme_pkg::OP_EMIT) |=> (state_q == ST_LOAD))
		else $error("emit did not return to load");
	a_final_end_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bstme_pkg::OP_K_END && sts.final_run) |=> (state_q == ST_OUT))
		else $error("final pass did not go to output");

endmodule

### rtl/bstme_dp.sv
// Datapath: edge store, sort registers, search bounds, parent table,
// tree sum and result register. Depends on bstme_pkg and bstme_ram.
module bstme_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  bstme_pkg::cmd_t                         cmd,
	output bstme_pkg::status_t                      sts,
	input  logic [bstme_pkg::VTX_W-1:0]             from_vertex,
	input  logic [bstme_pkg::VTX_W-1:0]             to_vertex,
	input  logic [bstme_pkg::WT_W-1:0]              edge_weight,
	input  logic                                    cfg_we,
	input  logic                                    cfg_index,
	input  logic [bstme_pkg::SUM_W-1:0]             cfg_data,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [bstme_pkg::ANS_W-1:0]             min_edge_weight
);

	localparam int CW = bstme_pkg::CNT_W;
	localparam int VW = bstme_pkg::VIDX_W;
	localparam int XW = bstme_pkg::VTX_W;
	localparam int WW = bstme_pkg::WT_W;
	localparam int EW = bstme_pkg::EDGE_W;

	logic [XW-1:0] vc_q;
	logic [bstme_pkg::SUM_W-1:0] budget_q;
	logic [CW-1:0] cnt_q, i_q, j_q, pos_q, low_q, high_q, probe_q;
	logic [EW-1:0] hold_q, e_q;
	logic [VW-1:0] par_q [bstme_pkg::MAX_VERTICES];
	logic [VW-1:0] v_q, x_q, ra_q;
	logic [bstme_pkg::SUM_W-1:0] sum_q;
	logic [XW-1:0] merges_q;
	logic [bstme_pkg::ANS_W-1:0] best_q, res_q;
	logic final_q, out_valid_q;

	logic ram_we;
	logic [bstme_pkg::EADDR_W-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, rdata;
	logic [XW-1:0] n_used, a_v, b_v;
	logic [CW-1:0] probe;
	logic [CW-1:0] j_m1;
	logic [VW-1:0] par_x;
	logic ok;

	bstme_ram #(.WIDTH(EW), .DEPTH(bstme_pkg::MAX_EDGES)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(rdata)
	);

	always_comb begin
		if (vc_q < XW'(2)) n_used = XW'(2);
		else if (vc_q > XW'(bstme_pkg::MAX_VERTICES)) n_used = XW'(bstme_pkg::MAX_VERTICES);
		else n_used = vc_q;
	end

	assign a_v = rdata[EW-1 -: XW];
	assign b_v = rdata[EW-XW-1 -: XW];
	assign probe = CW'(({1'b0, low_q} + {1'b0, high_q} + (CW+1)'(1)) >> 1);
	assign j_m1 = j_q - CW'(1);
	assign par_x = par_q[x_q];
	assign ok = (merges_q == n_used - XW'(1)) && (sum_q <= budget_q);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = j_q[bstme_pkg::EADDR_W-1:0];
		ram_wdata = hold_q;
		ram_raddr = pos_q[bstme_pkg::EADDR_W-1:0];
		case (cmd.op)
			bstme_pkg::OP_LOAD: begin
				ram_we = (cnt_q < CW'(bstme_pkg::MAX_EDGES));
				ram_waddr = cnt_q[bstme_pkg::EADDR_W-1:0];
				ram_wdata = {from_vertex, to_vertex, edge_weight};
			end
			bstme_pkg::OP_WR_HOLD: ram_we = 1'b1;
			bstme_pkg::OP_WR_SHIFT: begin
				ram_we = 1'b1;
				ram_wdata = rdata;
			end
			bstme_pkg::OP_RD_I: ram_raddr = i_q[bstme_pkg::EADDR_W-1:0];
			bstme_pkg::OP_RD_JM1: ram_raddr = j_m1[bstme_pkg::EADDR_W-1:0];
			default: ;
		endcase
	end

	assign sts.i_lt_cnt = (i_q < cnt_q);
	assign sts.j_zero = (j_q == '0);
	assign sts.cmp_gt = (rdata[WW-1:0] > hold_q[WW-1:0]);
	assign sts.v_last = (v_q == VW'(bstme_pkg::MAX_VERTICES - 1));
	assign sts.pos_lt_cnt = (pos_q < cnt_q);
	assign sts.range_ok = (a_v != '0) && (a_v <= n_used) && (b_v != '0) && (b_v <= n_used);
	assign sts.is_root = (par_x == x_q);
	assign sts.final_run = final_q;
	assign sts.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		case (cmd.op)
			bstme_pkg::OP_LOAD: i_q <= CW'(1);
			bstme_pkg::OP_HOLD: begin
				hold_q <= rdata;
				j_q <= i_q;
			end
			bstme_pkg::OP_WR_HOLD: i_q <= i_q + CW'(1);
			bstme_pkg::OP_WR_SHIFT: j_q <= j_q - CW'(1);
			bstme_pkg::OP_PROBE: begin
				probe_q <= probe;
				v_q <= '0;
				pos_q <= (low_q < high_q) ? probe : low_q;
			end
			bstme_pkg::OP_K_INIT: begin
				par_q[v_q] <= v_q;
				v_q <= v_q + VW'(1);
				sum_q <= '0;
				merges_q <= '0;
				best_q <= bstme_pkg::ANSWER_CAP;
			end
			bstme_pkg::OP_K_LD: begin
				e_q <= rdata;
				x_q <= VW'(a_v - XW'(1));
				if (!sts.range_ok) pos_q <= pos_q + CW'(1);
			end
			bstme_pkg::OP_FA: begin
				if (sts.is_root) begin
					ra_q <= x_q;
					x_q <= VW'(e_q[EW-XW-1 -: XW] - XW'(1));
				end else begin
					x_q <= par_x;
				end
			end
			bstme_pkg::OP_FB: begin
				if (sts.is_root) begin
					if (ra_q != x_q) begin
						par_q[ra_q] <= x_q;
						merges_q <= merges_q + XW'(1);
						sum_q <= sum_q + bstme_pkg::SUM_W'(e_q[WW-1:0]);
						if (e_q[WW-1:0] < WW'(best_q)) best_q <= e_q[bstme_pkg::ANS_W-1:0];
					end
					pos_q <= pos_q + CW'(1);
				end else begin
					x_q <= par_x;
				end
			end
			bstme_pkg::OP_EMIT: res_q <= best_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= XW'(2);
			budget_q <= '0;
			cnt_q <= '0;
			low_q <= '0;
			high_q <= '0;
			final_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bstme_pkg::CFG_VERTEX_COUNT) vc_q <= cfg_data[XW-1:0];
				else budget_q <= cfg_data;
			end
			out_valid_q <= (out_valid_q && out_stall) || (cmd.op == bstme_pkg::OP_EMIT);
			case (cmd.op)
				bstme_pkg::OP_LOAD: begin
					if (cnt_q < CW'(bstme_pkg::MAX_EDGES)) cnt_q <= cnt_q + CW'(1);
				end
				bstme_pkg::OP_SRCH_INIT: begin
					low_q <= '0;
					high_q <= cnt_q - CW'(1);
				end
				bstme_pkg::OP_PROBE: final_q <= !(low_q < high_q);
				bstme_pkg::OP_K_END: begin
					if (!final_q) begin
						if (ok) low_q <= probe_q;
						else high_q <= probe_q - CW'(1);
					end
				end
				bstme_pkg::OP_EMIT: cnt_q <= '0;
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign min_edge_weight = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(bstme_pkg::MAX_EDGES))
		else $error("edge count beyond store depth");
	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= high_q)
		else $error("search bounds crossed");
	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bstme_pkg::OP_EMIT) |=> out_valid_q)
		else $error("emit without output beat");
	a_merge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bstme_pkg::OP_FB) |-> (merges_q < XW'(bstme_pkg::MAX_VERTICES)))
		else $error("too many merges");

endmodule

### rtl/budget_spanning_tree_min_edge_top.sv
// Load: one edge beat per cycle. After the last edge: insertion sort (quadratic
// in edge count), then at most ceil(log2(edges))+1 union-find passes, each a probe
// step, parent init, a read and a load per edge, find steps on both endpoints of
// each in-range edge, and a close step. The result is registered on emit after the
// final pass, later while an earlier result stalls; input stalls until then.
// Async reset clears control; edge store and parent table are not cleared.
module budget_spanning_tree_min_edge_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bstme_pkg::VTX_W-1:0]         from_vertex,
	input  logic [bstme_pkg::VTX_W-1:0]         to_vertex,
	input  logic [bstme_pkg::WT_W-1:0]          edge_weight,
	input  logic                                last_edge,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bstme_pkg::ANS_W-1:0]         min_edge_weight,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [bstme_pkg::SUM_W-1:0]         cfg_data
);

	bstme_pkg::cmd_t cmd;
	bstme_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	bstme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_edge(last_edge),
		.in_stall(in_stall), .sts(sts), .cmd(cmd)
	);

	bstme_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.from_vertex(from_vertex), .to_vertex(to_vertex), .edge_weight(edge_weight),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall), .min_edge_weight(min_edge_weight)
	);

endmodule
